// File: rtl/core/rth_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rth_pkg
// Widths, divider geometry and the hand-over type shared by the RGB to HSL
// conversion pipeline.
// ----------------------------------------------------------------------------
package rth_pkg;

  localparam int CH_W    = 8;   // colour component
  localparam int HUE_W   = 16;
  localparam int SAT_W   = 16;
  localparam int LIGHT_W = 9;   // max + min

  // restoring dividers: 16 quotient bits, two per stage
  localparam int QUO_W      = 16;
  localparam int DIV_BITS   = 2;
  localparam int DIV_STAGES = QUO_W / DIV_BITS;

  localparam int HUE_DEN_W = 11;  // 6 * (max - min) <= 1530
  localparam int SAT_DEN_W = 8;   // min(s, 510 - s) <= 255

  // operands handed from the front end to the divider pipeline
  typedef struct packed {
    logic [HUE_DEN_W-1:0] hue_rem;  // sector position, below hue_den
    logic [HUE_DEN_W-1:0] hue_den;
    logic [SAT_DEN_W-1:0] sat_rem;  // top byte of d * 65535, below sat_den
    logic [QUO_W-1:0]     sat_lo;   // low bits of d * 65535, shifted in msb first
    logic [SAT_DEN_W-1:0] sat_den;
    logic [LIGHT_W-1:0]   light;
  } rth_div_t;

endpackage
`default_nettype wire

// File: rtl/core/rth_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rth_rgb_if / rth_hsl_if
// Valid/ready channels for RGB pixels in and HSL results out.
// ----------------------------------------------------------------------------
interface rth_rgb_if import rth_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

interface rth_hsl_if import rth_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [HUE_W-1:0]   hue;
  logic [SAT_W-1:0]   saturation;
  logic [LIGHT_W-1:0] lightness_doubled;

  modport source (output valid, hue, saturation, lightness_doubled, input ready);
  modport sink   (input valid, hue, saturation, lightness_doubled, output ready);
endinterface
`default_nettype wire

// File: rtl/core/rth_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rth_front
// Two register stages: extremes and sector term, then divider operands.
// ----------------------------------------------------------------------------
module rth_front import rth_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [CH_W-1:0] red,
  input  wire logic [CH_W-1:0] green,
  input  wire logic [CH_W-1:0] blue,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output rth_div_t             out_data
);

  localparam logic [1:0] SEL_RED = 2'd0;
  localparam logic [1:0] SEL_GRN = 2'd1;
  localparam logic [1:0] SEL_BLU = 2'd2;

  logic            v1_r, v2_r;
  logic            rdy1, rdy2;
  logic [CH_W-1:0] mx_r, mn_r, mx_nxt, mn_nxt;
  logic [1:0]      sel_r, sel_nxt;
  logic [CH_W:0]   diff_r, diff_nxt;   // two's complement
  rth_div_t        data_r, data_nxt;

  assign rdy2      = !v2_r || out_ready;
  assign rdy1      = !v1_r || rdy2;
  assign in_ready  = rdy1;
  assign out_valid = v2_r;
  assign out_data  = data_r;

  // stage 1: largest and smallest component, ties for largest go red, green, blue
  always_comb begin
    if (red >= green && red >= blue) begin
      sel_nxt  = SEL_RED;
      mx_nxt   = red;
      diff_nxt = {1'b0, green} - {1'b0, blue};
    end else if (green >= blue) begin
      sel_nxt  = SEL_GRN;
      mx_nxt   = green;
      diff_nxt = {1'b0, blue} - {1'b0, red};
    end else begin
      sel_nxt  = SEL_BLU;
      mx_nxt   = blue;
      diff_nxt = {1'b0, red} - {1'b0, green};
    end
    if (red <= green && red <= blue) begin
      mn_nxt = red;
    end else if (green <= blue) begin
      mn_nxt = green;
    end else begin
      mn_nxt = blue;
    end
  end

  // stage 2: sector position and divider operands
  logic [CH_W-1:0]      d;
  logic [LIGHT_W-1:0]   s, s_flip;
  logic [HUE_DEN_W-1:0] d6;
  logic [HUE_DEN_W:0]   dx, p;
  logic [CH_W+QUO_W-1:0] sat_num;
  logic                 gray;

  always_comb begin
    d       = mx_r - mn_r;
    s       = {1'b0, mx_r} + {1'b0, mn_r};
    s_flip  = 9'd510 - s;
    gray    = (d == '0);
    d6      = {1'b0, d, 2'b00} + {2'b00, d, 1'b0};
    dx      = {{3{diff_r[CH_W]}}, diff_r};
    sat_num = {d, {QUO_W{1'b0}}} - {{QUO_W{1'b0}}, d};
    unique case (sel_r)
      SEL_RED: p = dx + (diff_r[CH_W] ? {1'b0, d6} : '0);   // wrap by six sectors
      SEL_GRN: p = dx + {3'b000, d, 1'b0};
      SEL_BLU: p = dx + {2'b00, d, 2'b00};
      default: p = '0;
    endcase
    // a gray pixel divides zero by one, so both quotients come out zero
    data_nxt.hue_rem = p[HUE_DEN_W-1:0];
    data_nxt.hue_den = gray ? HUE_DEN_W'(1) : d6;
    data_nxt.sat_rem = sat_num[CH_W+QUO_W-1:QUO_W];
    data_nxt.sat_lo  = sat_num[QUO_W-1:0];
    if (gray) begin
      data_nxt.sat_den = SAT_DEN_W'(1);
    end else if (s > 9'd255) begin
      data_nxt.sat_den = s_flip[SAT_DEN_W-1:0];
    end else begin
      data_nxt.sat_den = s[SAT_DEN_W-1:0];
    end
    data_nxt.light = s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      mx_r   <= mx_nxt;
      mn_r   <= mn_nxt;
      sel_r  <= sel_nxt;
      diff_r <= diff_nxt;
    end
    if (rdy2 && v1_r) begin
      data_r <= data_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/rth_div_pipe.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rth_div_pipe
// Pipelined restoring dividers for hue and saturation, lightness alongside.
// ----------------------------------------------------------------------------
module rth_div_pipe import rth_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire rth_div_t      in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [HUE_W-1:0]   hue,
  output logic [SAT_W-1:0]   saturation,
  output logic [LIGHT_W-1:0] lightness_doubled
);

  localparam int HDW  = HUE_DEN_W;
  localparam int SDW  = SAT_DEN_W;
  localparam int LAST = DIV_STAGES - 1;

  logic                 v_r       [DIV_STAGES];
  logic [HDW-1:0]       hrem_r    [DIV_STAGES];
  logic [HDW-1:0]       hden_r    [DIV_STAGES];
  logic [QUO_W-1:0]     hq_r      [DIV_STAGES];
  logic [SDW-1:0]       srem_r    [DIV_STAGES];
  logic [QUO_W-1:0]     slo_r     [DIV_STAGES];
  logic [SDW-1:0]       sden_r    [DIV_STAGES];
  logic [QUO_W-1:0]     sq_r      [DIV_STAGES];
  logic [LIGHT_W-1:0]   light_r   [DIV_STAGES];

  logic                 src_v     [DIV_STAGES];
  logic [HDW-1:0]       src_hrem  [DIV_STAGES];
  logic [HDW-1:0]       src_hden  [DIV_STAGES];
  logic [QUO_W-1:0]     src_hq    [DIV_STAGES];
  logic [SDW-1:0]       src_srem  [DIV_STAGES];
  logic [QUO_W-1:0]     src_slo   [DIV_STAGES];
  logic [SDW-1:0]       src_sden  [DIV_STAGES];
  logic [QUO_W-1:0]     src_sq    [DIV_STAGES];
  logic [LIGHT_W-1:0]   src_light [DIV_STAGES];

  logic                 rdy       [DIV_STAGES+1];

  assign rdy[DIV_STAGES] = out_ready;

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
    logic [HDW-1:0]   hrem_nxt;
    logic [QUO_W-1:0] hq_nxt;
    logic [SDW-1:0]   srem_nxt;
    logic [QUO_W-1:0] slo_nxt;
    logic [QUO_W-1:0] sq_nxt;

    if (i == 0) begin : g_head
      assign src_v[i]     = in_valid;
      assign src_hrem[i]  = in_data.hue_rem;
      assign src_hden[i]  = in_data.hue_den;
      assign src_hq[i]    = '0;
      assign src_srem[i]  = in_data.sat_rem;
      assign src_slo[i]   = in_data.sat_lo;
      assign src_sden[i]  = in_data.sat_den;
      assign src_sq[i]    = '0;
      assign src_light[i] = in_data.light;
    end else begin : g_link
      assign src_v[i]     = v_r[i-1];
      assign src_hrem[i]  = hrem_r[i-1];
      assign src_hden[i]  = hden_r[i-1];
      assign src_hq[i]    = hq_r[i-1];
      assign src_srem[i]  = srem_r[i-1];
      assign src_slo[i]   = slo_r[i-1];
      assign src_sden[i]  = sden_r[i-1];
      assign src_sq[i]    = sq_r[i-1];
      assign src_light[i] = light_r[i-1];
    end

    assign rdy[i] = !v_r[i] || rdy[i+1];

    // remainder stays below the divisor, so each trial fits one extra bit
    always_comb begin : p_div
      logic [HDW:0] ht;
      logic [SDW:0] st;
      hrem_nxt = src_hrem[i];
      hq_nxt   = src_hq[i];
      srem_nxt = src_srem[i];
      slo_nxt  = src_slo[i];
      sq_nxt   = src_sq[i];
      for (int k = 0; k < DIV_BITS; k++) begin
        ht = {hrem_nxt, 1'b0};
        if (ht >= {1'b0, src_hden[i]}) begin
          hrem_nxt = HDW'(ht - {1'b0, src_hden[i]});
          hq_nxt   = {hq_nxt[QUO_W-2:0], 1'b1};
        end else begin
          hrem_nxt = ht[HDW-1:0];
          hq_nxt   = {hq_nxt[QUO_W-2:0], 1'b0};
        end
        st      = {srem_nxt, slo_nxt[QUO_W-1]};
        slo_nxt = {slo_nxt[QUO_W-2:0], 1'b0};
        if (st >= {1'b0, src_sden[i]}) begin
          srem_nxt = SDW'(st - {1'b0, src_sden[i]});
          sq_nxt   = {sq_nxt[QUO_W-2:0], 1'b1};
        end else begin
          srem_nxt = st[SDW-1:0];
          sq_nxt   = {sq_nxt[QUO_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (rdy[i]) begin
        v_r[i] <= src_v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i] && src_v[i]) begin
        hrem_r[i]  <= hrem_nxt;
        hden_r[i]  <= src_hden[i];
        hq_r[i]    <= hq_nxt;
        srem_r[i]  <= srem_nxt;
        slo_r[i]   <= slo_nxt;
        sden_r[i]  <= src_sden[i];
        sq_r[i]    <= sq_nxt;
        light_r[i] <= src_light[i];
      end
    end
  end

  assign in_ready          = rdy[0];
  assign out_valid         = v_r[LAST];
  assign hue               = hq_r[LAST];
  assign saturation        = sq_r[LAST];
  assign lightness_doubled = light_r[LAST];

endmodule
`default_nettype wire

// File: rtl/core/rgb_to_hsl_converter.sv
`default_nettype none
// The pipeline has 2 front-end stages and 8 divider stages at 2 quotient
// bits each. Throughput: one pixel per cycle while out_hsl.ready is high.
// Each stage takes a new beat each cycle when empty or the next one moves.
// Each stage holds its beat while stalled; bubbles still fill behind it.
// Reset clears the stage valid flags only; data registers are not reset.
// ----------------------------------------------------------------------------
// rgb_to_hsl_converter
// Streams 8-bit RGB pixels to fixed-point hue, saturation and 2x lightness.
// ----------------------------------------------------------------------------
module rgb_to_hsl_converter import rth_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  rth_rgb_if.sink    in_pix,
  rth_hsl_if.source  out_hsl
);

  logic     f_valid;
  logic     f_ready;
  rth_div_t f_data;

  rth_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_pix.valid),
    .in_ready  (in_pix.ready),
    .red       (in_pix.red),
    .green     (in_pix.green),
    .blue      (in_pix.blue),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_data  (f_data)
  );

  rth_div_pipe u_div (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (f_valid),
    .in_ready          (f_ready),
    .in_data           (f_data),
    .out_valid         (out_hsl.valid),
    .out_ready         (out_hsl.ready),
    .hue               (out_hsl.hue),
    .saturation        (out_hsl.saturation),
    .lightness_doubled (out_hsl.lightness_doubled)
  );

endmodule
`default_nettype wire

// File: rtl/core/rth_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rth_checker
// Port-level checks for the RGB to HSL converter, bound to the top level.
// ----------------------------------------------------------------------------
module rth_checker import rth_pkg::*; (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [HUE_W-1:0]   hue,
  input wire logic [SAT_W-1:0]   saturation,
  input wire logic [LIGHT_W-1:0] lightness_doubled
);

  // a stalled result beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(hue) && $stable(saturation)
      && $stable(lightness_doubled))
    else $error("result beat changed while stalled");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // with no result waiting every stage can move, so input is taken
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // zero saturation only arises from a gray pixel, whose hue is zero
  a_gray_hue: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && saturation == '0 |-> hue == '0)
    else $error("non-zero hue on gray pixel");

  // black and white are gray
  a_black_white: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (lightness_doubled == 9'd0 || lightness_doubled == 9'd510)
      |-> saturation == '0)
    else $error("saturation on black or white pixel");

endmodule

bind rgb_to_hsl_converter rth_checker u_rth_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_pix.ready),
  .out_valid         (out_hsl.valid),
  .out_ready         (out_hsl.ready),
  .hue               (out_hsl.hue),
  .saturation        (out_hsl.saturation),
  .lightness_doubled (out_hsl.lightness_doubled)
);
`default_nettype wire
